[rtl/ipv4hg_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4hg_pkg
// shared types, constants and the header byte selection for the ipv4 header
// generator
// ----------------------------------------------------------------------------
package ipv4hg_pkg;

	localparam logic [7:0]  VER_IHL       = 8'h45;
	localparam logic [7:0]  TTL_VALUE     = 8'h80;
	localparam logic [4:0]  LAST_IDX      = 5'd19;
	localparam logic [15:0] ID_STEP_RESET = 16'd20795;
	localparam logic [15:0] IDENT_RESET   = 16'd30859;

	// register map, word index
	localparam logic REG_ID_STEP = 1'b0;

	typedef struct packed {
		logic [15:0] total_length;
		logic [7:0]  protocol;
		logic [15:0] ident;
		logic [15:0] csum;
		logic [31:0] source_address;
		logic [31:0] dest_address;
	} hdr_desc_t;

	function automatic logic [7:0] hdr_byte(input hdr_desc_t d, input logic [4:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0:    b = VER_IHL;
			5'd1:    b = 8'h00;
			5'd2:    b = d.total_length[15:8];
			5'd3:    b = d.total_length[7:0];
			5'd4:    b = d.ident[15:8];
			5'd5:    b = d.ident[7:0];
			5'd6:    b = 8'h00;
			5'd7:    b = 8'h00;
			5'd8:    b = TTL_VALUE;
			5'd9:    b = d.protocol;
			5'd10:   b = d.csum[15:8];
			5'd11:   b = d.csum[7:0];
			5'd12:   b = d.source_address[31:24];
			5'd13:   b = d.source_address[23:16];
			5'd14:   b = d.source_address[15:8];
			5'd15:   b = d.source_address[7:0];
			5'd16:   b = d.dest_address[31:24];
			5'd17:   b = d.dest_address[23:16];
			5'd18:   b = d.dest_address[15:8];
			5'd19:   b = d.dest_address[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[rtl/ipv4hg_front.sv]
// ----------------------------------------------------------------------------
// ipv4hg_front
// accepts requests, advances the identification counter and builds the
// header checksum over two pipeline stages
// ----------------------------------------------------------------------------
module ipv4hg_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           total_length,
	input  logic [7:0]            protocol,
	input  logic [31:0]           source_address,
	input  logic [31:0]           dest_address,
	input  logic [15:0]           id_step,
	output logic                  push_valid,
	input  logic                  push_ready,
	output ipv4hg_pkg::hdr_desc_t push_desc
);

	logic [15:0] ident_q;
	logic        v_s1;
	logic        v_s2;
	logic [15:0] tlen_s1, tlen_s2;
	logic [7:0]  proto_s1, proto_s2;
	logic [15:0] ident_s1, ident_s2;
	logic [31:0] src_s1, src_s2;
	logic [31:0] dst_s1, dst_s2;
	logic [17:0] sum_a_s2;
	logic [17:0] sum_b_s2;
	logic        adv_s1;
	logic        adv_s2;
	logic        in_beat;
	logic [15:0] ident_next;
	logic [17:0] sum_a;
	logic [17:0] sum_b;
	logic [18:0] sum_all;
	logic [16:0] fold1;
	logic [16:0] fold2;

	assign adv_s2     = !v_s2 || push_ready;
	assign adv_s1     = !v_s1 || adv_s2;
	assign in_ready   = adv_s1;
	assign in_beat    = in_valid && adv_s1;
	assign ident_next = ident_q + id_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= ipv4hg_pkg::IDENT_RESET;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (in_beat) ident_q <= ident_next;
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	// partial checksum sums
	assign sum_a = {2'b00, tlen_s1} + {2'b00, ident_s1}
		+ {2'b00, src_s1[31:16]} + {2'b00, src_s1[15:0]};
	assign sum_b = {2'b00, dst_s1[31:16]} + {2'b00, dst_s1[15:0]}
		+ {2'b00, ipv4hg_pkg::VER_IHL, 8'h00} + {2'b00, ipv4hg_pkg::TTL_VALUE, proto_s1};

	always_ff @(posedge clk) begin
		if (in_beat) begin
			tlen_s1  <= total_length;
			proto_s1 <= protocol;
			ident_s1 <= ident_next;
			src_s1   <= source_address;
			dst_s1   <= dest_address;
		end
		if (adv_s2 && v_s1) begin
			tlen_s2  <= tlen_s1;
			proto_s2 <= proto_s1;
			ident_s2 <= ident_s1;
			src_s2   <= src_s1;
			dst_s2   <= dst_s1;
			sum_a_s2 <= sum_a;
			sum_b_s2 <= sum_b;
		end
	end

	// end-around carry fold
	assign sum_all = {1'b0, sum_a_s2} + {1'b0, sum_b_s2};
	assign fold1   = {1'b0, sum_all[15:0]} + {14'd0, sum_all[18:16]};
	assign fold2   = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

	always_comb begin
		push_desc.total_length   = tlen_s2;
		push_desc.protocol       = proto_s2;
		push_desc.ident          = ident_s2;
		push_desc.csum           = ~fold2[15:0];
		push_desc.source_address = src_s2;
		push_desc.dest_address   = dst_s2;
	end

	assign push_valid = v_s2;

endmodule

[rtl/ipv4hg_fifo.sv]
// ----------------------------------------------------------------------------
// ipv4hg_fifo
// short queue of finished header descriptors between front and back
// ----------------------------------------------------------------------------
module ipv4hg_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  ipv4hg_pkg::hdr_desc_t push_desc,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output ipv4hg_pkg::hdr_desc_t pop_desc
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	ipv4hg_pkg::hdr_desc_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_desc   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_desc;
	end

endmodule

[rtl/ipv4hg_back.sv]
// ----------------------------------------------------------------------------
// ipv4hg_back
// serialises one header descriptor into twenty registered output beats
// ----------------------------------------------------------------------------
module ipv4hg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  ipv4hg_pkg::hdr_desc_t pop_desc,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            header_byte,
	output logic [4:0]            byte_index,
	output logic                  last_byte
);

	ipv4hg_pkg::hdr_desc_t cur_q;
	logic                  cur_v_q;
	logic [4:0]            cnt_q;
	logic                  out_v_q;
	logic                  load;
	logic                  at_last;
	logic                  do_pop;

	assign load      = !out_v_q || out_ready;
	assign at_last   = (cnt_q == ipv4hg_pkg::LAST_IDX);
	assign pop_ready = !cur_v_q || (load && at_last);
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) out_v_q <= cur_v_q;
			if (do_pop) begin
				cur_v_q <= 1'b1;
				cnt_q   <= '0;
			end else if (load && cur_v_q) begin
				if (at_last) cur_v_q <= 1'b0;
				cnt_q <= at_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) cur_q <= pop_desc;
		if (load && cur_v_q) begin
			header_byte <= ipv4hg_pkg::hdr_byte(cur_q, cnt_q);
			byte_index  <= cnt_q;
			last_byte   <= at_last;
		end
	end

	assign out_valid = out_v_q;

endmodule

[rtl/ipv4_header_generator.sv]
// ----------------------------------------------------------------------------
// ipv4_header_generator
// builds 20-byte ipv4 headers with identification and checksum, one byte
// per output beat
// ----------------------------------------------------------------------------
// first byte path: checksum stages, queue, descriptor and output registers
// each request yields twenty beats through the byte-wide output register
// requests queue behind the checksum stages while a header is being sent
// reset: asynchronous, clears pipeline and queue; id_step returns to 20795,
// identification counter to 30859
// ----------------------------------------------------------------------------
module ipv4_header_generator #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] total_length,
	input  logic [7:0]  protocol,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  header_byte,
	output logic [4:0]  byte_index,
	output logic        last_byte
);

	logic [15:0]           id_step_q;
	logic                  push_valid;
	logic                  push_ready;
	ipv4hg_pkg::hdr_desc_t push_desc;
	logic                  pop_valid;
	logic                  pop_ready;
	ipv4hg_pkg::hdr_desc_t pop_desc;
	logic                  sel_id_step;

	// register file
	assign pready      = 1'b1;
	assign sel_id_step = (paddr[2] == ipv4hg_pkg::REG_ID_STEP);
	assign prdata      = sel_id_step ? {16'd0, id_step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_step_q <= ipv4hg_pkg::ID_STEP_RESET;
		end else if (psel && penable && pwrite && pready && sel_id_step) begin
			id_step_q <= pwdata[15:0];
		end
	end

	ipv4hg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.total_length   (total_length),
		.protocol       (protocol),
		.source_address (source_address),
		.dest_address   (dest_address),
		.id_step        (id_step_q),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_desc      (push_desc)
	);

	ipv4hg_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	ipv4hg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_desc    (pop_desc),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.header_byte (header_byte),
		.byte_index  (byte_index),
		.last_byte   (last_byte)
	);

endmodule

[rtl/ipv4hg_checker.sv]
// ----------------------------------------------------------------------------
// ipv4hg_checker
// port-level checks on the header byte stream, bound to the top level
// ----------------------------------------------------------------------------
module ipv4hg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] header_byte,
	input logic [4:0] byte_index,
	input logic       last_byte
);

	// last marker only on the final byte
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_byte == (byte_index == 5'd19)))
		else $error("last_byte does not match byte_index");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_index <= 5'd19))
		else $error("byte_index out of range");

	// bytes of one header follow without gaps
	a_next_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_byte) |=>
			(out_valid && (byte_index == $past(byte_index) + 5'd1)))
		else $error("header byte missing or out of order");

	a_new_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_byte) |=> (!out_valid || (byte_index == 5'd0)))
		else $error("new header does not start at byte zero");

	a_ver_ihl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (byte_index == 5'd0)) |-> (header_byte == 8'h45))
		else $error("wrong version and header length byte");

endmodule

bind ipv4_header_generator ipv4hg_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.header_byte (header_byte),
	.byte_index  (byte_index),
	.last_byte   (last_byte)
);

[tb/sv/ipv4_header_checker.sv]
// ----------------------------------------------------------------------------
// ipv4_header_checker
// follows id_step writes on the register port, builds the expected 20-byte
// header for every request beat and compares each output beat field by field
// against the oldest expected byte
// ----------------------------------------------------------------------------
module ipv4_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] total_length,
	input  logic [7:0]  protocol,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  header_byte,
	input  logic [4:0]  byte_index,
	input  logic        last_byte,
	output int          fail_count,
	output int          pending_beats
);

	typedef struct packed {
		logic [7:0] hbyte;
		logic [4:0] idx;
		logic       last;
	} hdr_beat_t;

	logic [15:0] step_value;
	logic [15:0] ident_value;
	hdr_beat_t   header_q[$];

	initial begin
		fail_count    = 0;
		pending_beats = 0;
	end

	// header bytes 0..19 packed msb first, byte i at [159-8*i -: 8]
	function automatic logic [159:0] ipv4_header_bytes(input logic [15:0] tlen,
			input logic [7:0] proto, input logic [31:0] src, input logic [31:0] dst,
			input logic [15:0] ident);
		logic [159:0] hdr;
		int unsigned  acc;
		logic [15:0]  csum;
		hdr = {ipv4hg_pkg::VER_IHL, 8'h00, tlen, ident, 16'h0000,
			ipv4hg_pkg::TTL_VALUE, proto, 16'h0000, src, dst};
		acc = 0;
		for (int w = 0; w < 10; w++)
			acc += hdr[159 - 16 * w -: 16];
		while ((acc >> 16) != 0)
			acc = (acc & 32'hFFFF) + (acc >> 16);
		csum = ~acc[15:0];
		hdr[159 - 80 -: 16] = csum;
		return hdr;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		$display("mismatch at %0t: %s, got 0x%0h, expected 0x%0h", $realtime, what,
			seen, wanted);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_value  = ipv4hg_pkg::ID_STEP_RESET;
			ident_value = ipv4hg_pkg::IDENT_RESET;
			header_q.delete();
		end else begin
			logic [159:0] hdr;
			hdr_beat_t    want;
			if (psel && penable && pwrite && pready
					&& paddr[2] == ipv4hg_pkg::REG_ID_STEP)
				step_value = pwdata[15:0];
			if (in_valid && in_ready) begin
				ident_value = ident_value + step_value;
				hdr = ipv4_header_bytes(total_length, protocol, source_address,
					dest_address, ident_value);
				for (int i = 0; i < 20; i++)
					header_q.push_back(hdr_beat_t'{hbyte: hdr[159 - 8 * i -: 8],
						idx: 5'(i), last: (5'(i) == ipv4hg_pkg::LAST_IDX)});
			end
			if (out_valid && out_ready) begin
				if (header_q.size() == 0) begin
					note_mismatch("output beat with no header byte pending",
						32'(header_byte), 32'd0);
				end else begin
					want = header_q.pop_front();
					if (header_byte !== want.hbyte)
						note_mismatch($sformatf("header_byte at index %0d", want.idx),
							32'(header_byte), 32'(want.hbyte));
					if (byte_index !== want.idx)
						note_mismatch("byte_index", 32'(byte_index), 32'(want.idx));
					if (last_byte !== want.last)
						note_mismatch($sformatf("last_byte at index %0d", want.idx),
							32'(last_byte), 32'(want.last));
				end
			end
		end
		pending_beats = header_q.size();
	end

endmodule

[tb/sv/tb_ipv4_header_generator.sv]
// ----------------------------------------------------------------------------
// tb_ipv4_header_generator
// drives header requests and id_step writes into the ipv4 header generator
// with random gaps and output stalls; a checker beside the block predicts
// every header byte and counts mismatches
// ----------------------------------------------------------------------------
module tb_ipv4_header_generator;

	localparam logic [2:0] ADDR_ID_STEP = {ipv4hg_pkg::REG_ID_STEP, 2'b00};
	localparam logic [2:0] ADDR_SPARE   = {~ipv4hg_pkg::REG_ID_STEP, 2'b00};

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [2:0]  paddr          = '0;
	logic [31:0] pwdata         = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [15:0] total_length   = '0;
	logic [7:0]  protocol       = '0;
	logic [31:0] source_address = '0;
	logic [31:0] dest_address   = '0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [7:0]  header_byte;
	logic [4:0]  byte_index;
	logic        last_byte;
	int          fail_count;
	int          pending_beats;
	bit          calm           = 1'b0;

	always #6 clk = ~clk;

	ipv4_header_generator uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.total_length(total_length), .protocol(protocol),
		.source_address(source_address), .dest_address(dest_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.header_byte(header_byte), .byte_index(byte_index), .last_byte(last_byte)
	);

	ipv4_header_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.total_length(total_length), .protocol(protocol),
		.source_address(source_address), .dest_address(dest_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.header_byte(header_byte), .byte_index(byte_index), .last_byte(last_byte),
		.fail_count(fail_count), .pending_beats(pending_beats)
	);

	// receiver stalls in bursts, none once calm
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// called at a rising edge, returns at the edge where the beat is taken
	task automatic offer_request(input logic [15:0] tlen, input logic [7:0] proto,
			input logic [31:0] src, input logic [31:0] dst);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		total_length   <= tlen;
		protocol       <= proto;
		source_address <= src;
		dest_address   <= dst;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// sender holds off until every header byte has come out
	task automatic wait_headers_done();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_beats != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] steps[5];
		logic [15:0] tlen;
		logic [7:0]  proto;
		steps = '{16'($urandom), 16'h0001, 16'hFFFF, 16'h0000, 16'($urandom)};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset step value first, then the extremes
		offer_request(16'd20, 8'd6, 32'hC0A8_0001, 32'hC0A8_00FF);
		offer_request(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_request(16'h0000, 8'h00, 32'h0000_0000, 32'h0000_0000);
		wait_headers_done();
		apb_write(ADDR_ID_STEP, {16'hDEAD, 16'h0000});
		offer_request(16'h0000, 8'h00, 32'h0000_0000, 32'h0000_0000);
		offer_request(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_request(16'h5555, 8'hAA, 32'hAAAA_AAAA, 32'h5555_5555);
		offer_request(16'hAAAA, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA);
		wait_headers_done();
		apb_write(ADDR_ID_STEP, {16'($urandom), 16'hFFFF});
		// write to an unmapped register must leave id_step alone
		apb_write(ADDR_SPARE, $urandom);
		offer_request(16'd40, 8'd17, 32'h0A00_0001, 32'h0A00_0002);
		offer_request(16'd1500, 8'd1, 32'h7F00_0001, 32'hE000_0001);
		offer_request(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_request(16'h0000, 8'h00, 32'h0000_0000, 32'h0000_0000);
		offer_request(16'd19, 8'hFF, 32'h0000_0001, 32'h8000_0000);
		wait_headers_done();

		for (int p = 0; p < 5; p++) begin
			apb_write(ADDR_ID_STEP, {16'($urandom), steps[p]});
			if ($urandom_range(0, 1) == 0)
				apb_write(ADDR_SPARE, $urandom);
			calm = (p == 4);
			for (int n = 0; n < 100; n++) begin
				tlen  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(20, 1500))
					: 16'($urandom);
				case ($urandom_range(0, 3))
					0:       proto = 8'd6;
					1:       proto = 8'd17;
					default: proto = 8'($urandom);
				endcase
				offer_request(tlen, proto, $urandom, $urandom);
			end
			wait_headers_done();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#6000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
